// ===== rtl/core/mee_pkg.sv =====
// Package for the Morse element encoder: sizes, codes, table entry type.
// No dependencies; imported by mee_match, the top level and the testbench.
`default_nettype none

package mee_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int MAX_CODE_LEN  = 8;

    localparam int SYM_W  = 8;
    localparam int PAT_W  = 8;
    localparam int LEN_W  = 4;
    localparam int DSYM_W = 7;
    localparam int KIND_W = 3;
    localparam int UNIT_W = 3;

    localparam int CODE_CAP = (MAX_CODE_LEN < PAT_W) ? MAX_CODE_LEN : PAT_W;
    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
    localparam int ELEM_W   = $clog2(PAT_W);
    localparam int ENTRY_W  = PAT_W + LEN_W;

    localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] SCAN_END  = CNT_W'(TABLE_ENTRIES);
    localparam logic [LEN_W-1:0] LEN_CAP   = LEN_W'(CODE_CAP);

    localparam logic [SYM_W-1:0] SPACE_SYM   = 8'h20;
    localparam logic [SYM_W-1:0] UPPER_A     = 8'h41;
    localparam logic [SYM_W-1:0] UPPER_Z     = 8'h5A;
    localparam logic [SYM_W-1:0] CASE_OFFSET = 8'h20;

    localparam logic [UNIT_W-1:0] DIT_UNITS  = 3'd1;
    localparam logic [UNIT_W-1:0] DAH_UNITS  = 3'd3;
    localparam logic [UNIT_W-1:0] GAP_UNITS  = 3'd2;
    localparam logic [UNIT_W-1:0] WORD_UNITS = 3'd6;
    localparam logic [UNIT_W-1:0] NO_UNITS   = 3'd0;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_ENCODE = 2'd2,
        CMD_DECODE = 2'd3
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DIT    = 3'd0,
        KIND_DAH    = 3'd1,
        KIND_GAP    = 3'd2,
        KIND_WORD   = 3'd3,
        KIND_ANSWER = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_GAP,
        ST_ELEM,
        ST_WORD,
        ST_SCAN,
        ST_ANS
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic [PAT_W-1:0] pattern;
    } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/mee_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mee_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/mee_match.sv =====
// Compare unit: table entry against a pattern/length key.
// Depends on mee_pkg.
`default_nettype none

module mee_match (
    input  wire mee_pkg::entry_t entry,
    input  wire mee_pkg::entry_t key,
    output logic                 hit
);
    import mee_pkg::*;

    logic [PAT_W-1:0] mask;

    always_comb begin
        for (int i = 0; i < PAT_W; i++) begin
            mask[i] = (LEN_W'(i) < key.length);
        end
    end

    assign hit = (entry.length == key.length)
              && (((entry.pattern ^ key.pattern) & mask) == '0);

endmodule

`default_nettype wire

// ===== rtl/core/morse_element_encoder_unit.sv =====
// Morse element encoder top level: table RAM, valid bits, sequencer, output register.
// Depends on mee_pkg, mee_ram, mee_match.
// Clear and load: no results. Encode: accept, 1 table read, then one result
// per cycle while m_ready is high (up to 9); a space gives one word result.
// Decode: one table entry per cycle until a hit or the table end, then the answer.
// Sync reset clears valid bits, previous-character flag, sequencer, m_valid; not the table.
`default_nettype none

module morse_element_encoder_unit (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_command,
    input  wire logic [mee_pkg::SYM_W-1:0]   s_symbol,
    input  wire logic [mee_pkg::PAT_W-1:0]   s_code_pattern,
    input  wire logic [mee_pkg::LEN_W-1:0]   s_code_length,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mee_pkg::KIND_W-1:0]       m_kind,
    output logic [mee_pkg::UNIT_W-1:0]       m_units,
    output logic                             m_key_down,
    output logic [mee_pkg::DSYM_W-1:0]       m_decoded_symbol,
    output logic                             m_found,
    output logic                             m_last
);
    import mee_pkg::*;

    state_t state_reg, state_next;

    logic [TABLE_ENTRIES-1:0] entry_valid_reg, entry_valid_next;
    logic                     prev_reg, prev_next;
    entry_t                   key_reg, key_next;
    entry_t                   entry_reg, entry_next;
    logic [ELEM_W-1:0]        elem_reg, elem_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]         pipe_idx_reg, pipe_idx_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic                     hit_found_reg, hit_found_next;

    logic                     m_valid_reg, m_valid_next;
    kind_t                    kind_reg, kind_next;
    logic [UNIT_W-1:0]        units_reg, units_next;
    logic                     key_down_reg, key_down_next;
    logic [DSYM_W-1:0]        dsym_reg, dsym_next;
    logic                     found_reg, found_next;
    logic                     last_reg, last_next;

    logic             s_accept;
    logic             out_free;
    logic [SYM_W-1:0] lc_sym;
    logic [IDX_W-1:0] enc_idx;
    logic             enc_known;
    logic             is_space;
    logic             load_ok;
    logic [LEN_W-1:0] load_len;
    logic             elem_last;
    logic             scan_in_range;
    logic             scan_hit;
    logic             match_hit;

    logic             ram_we;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;

    mee_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s_symbol[IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mee_match u_match (
        .entry (ram_rdata),
        .key   (key_reg),
        .hit   (match_hit)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign lc_sym    = (s_symbol inside {[UPPER_A:UPPER_Z]}) ? s_symbol + CASE_OFFSET
                                                            : s_symbol;
    assign enc_idx   = lc_sym[IDX_W-1:0];
    assign enc_known = ({1'b0, lc_sym} < SYM_LIMIT) && entry_valid_reg[enc_idx];
    assign is_space  = (s_symbol == SPACE_SYM);
    assign load_ok   = ({1'b0, s_symbol} < SYM_LIMIT);
    assign load_len  = (s_code_length > LEN_CAP) ? LEN_CAP : s_code_length;
    assign ram_wdata = '{length: load_len, pattern: s_code_pattern};

    assign elem_last     = ((LEN_W'(elem_reg) + LEN_W'(1)) == entry_reg.length);
    assign scan_in_range = (cnt_reg < SCAN_END);
    assign scan_hit      = pipe_vld_reg && match_hit;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (cmd_t'(s_command))
                        CMD_ENCODE: begin
                            if (is_space) begin
                                state_next = ST_WORD;
                            end else if (enc_known) begin
                                state_next = ST_FETCH;
                            end
                        end
                        CMD_DECODE: state_next = ST_SCAN;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_FETCH: begin
                if (prev_reg) begin
                    state_next = ST_GAP;
                end else if (ram_rdata.length == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_ELEM;
                end
            end
            ST_GAP: begin
                if (out_free) begin
                    state_next = (entry_reg.length == '0) ? ST_IDLE : ST_ELEM;
                end
            end
            ST_ELEM: begin
                if (out_free && elem_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WORD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_hit || !scan_in_range) begin
                    state_next = ST_ANS;
                end
            end
            ST_ANS: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        entry_valid_next = entry_valid_reg;
        prev_next        = prev_reg;
        key_next         = key_reg;
        entry_next       = entry_reg;
        elem_next        = elem_reg;
        cnt_next         = cnt_reg;
        pipe_vld_next    = 1'b0;
        pipe_idx_next    = pipe_idx_reg;
        hit_idx_next     = hit_idx_reg;
        hit_found_next   = hit_found_reg;
        ram_we           = 1'b0;
        ram_raddr        = enc_idx;

        m_valid_next  = m_valid_reg && !m_ready;
        kind_next     = kind_reg;
        units_next    = units_reg;
        key_down_next = key_down_reg;
        dsym_next     = dsym_reg;
        found_next    = found_reg;
        last_next     = last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    key_next      = '{length: s_code_length, pattern: s_code_pattern};
                    cnt_next      = '0;
                    hit_idx_next  = '0;
                    hit_found_next = 1'b0;
                    case (cmd_t'(s_command))
                        CMD_CLEAR: entry_valid_next = '0;
                        CMD_LOAD: begin
                            if (load_ok) begin
                                ram_we = 1'b1;
                                entry_valid_next[s_symbol[IDX_W-1:0]] = 1'b1;
                            end
                        end
                        CMD_ENCODE: begin
                            if (is_space) begin
                                prev_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                entry_next = ram_rdata;
                elem_next  = '0;
                prev_next  = 1'b1;
            end
            ST_GAP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    kind_next     = KIND_GAP;
                    units_next    = GAP_UNITS;
                    key_down_next = 1'b0;
                    dsym_next     = '0;
                    found_next    = 1'b0;
                    last_next     = (entry_reg.length == '0);
                end
            end
            ST_ELEM: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    kind_next     = entry_reg.pattern[elem_reg] ? KIND_DAH : KIND_DIT;
                    units_next    = entry_reg.pattern[elem_reg] ? DAH_UNITS : DIT_UNITS;
                    key_down_next = 1'b1;
                    dsym_next     = '0;
                    found_next    = 1'b0;
                    last_next     = elem_last;
                    elem_next     = elem_reg + ELEM_W'(1);
                end
            end
            ST_WORD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    kind_next     = KIND_WORD;
                    units_next    = WORD_UNITS;
                    key_down_next = 1'b0;
                    dsym_next     = '0;
                    found_next    = 1'b0;
                    last_next     = 1'b1;
                end
            end
            ST_SCAN: begin
                ram_raddr     = cnt_reg[IDX_W-1:0];
                pipe_vld_next = scan_in_range && entry_valid_reg[cnt_reg[IDX_W-1:0]];
                pipe_idx_next = cnt_reg[IDX_W-1:0];
                cnt_next      = cnt_reg + CNT_W'(1);
                if (scan_hit) begin
                    hit_idx_next   = pipe_idx_reg;
                    hit_found_next = 1'b1;
                end
            end
            ST_ANS: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    kind_next     = KIND_ANSWER;
                    units_next    = NO_UNITS;
                    key_down_next = 1'b0;
                    dsym_next     = DSYM_W'(hit_idx_reg);
                    found_next    = hit_found_reg;
                    last_next     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            entry_valid_reg <= '0;
            prev_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
            pipe_vld_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            entry_valid_reg <= entry_valid_next;
            prev_reg        <= prev_next;
            m_valid_reg     <= m_valid_next;
            pipe_vld_reg    <= pipe_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        entry_reg     <= entry_next;
        elem_reg      <= elem_next;
        cnt_reg       <= cnt_next;
        pipe_idx_reg  <= pipe_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_found_reg <= hit_found_next;
        kind_reg      <= kind_next;
        units_reg     <= units_next;
        key_down_reg  <= key_down_next;
        dsym_reg      <= dsym_next;
        found_reg     <= found_next;
        last_reg      <= last_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = kind_reg;
    assign m_units          = units_reg;
    assign m_key_down       = key_down_reg;
    assign m_decoded_symbol = dsym_reg;
    assign m_found          = found_reg;
    assign m_last           = last_reg;

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && (s_command == CMD_CLEAR) |=> (entry_valid_reg == '0))
        else $error("valid bits not cleared");

    a_found_is_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> (m_kind == KIND_ANSWER))
        else $error("found set on a non-decode transaction");

    a_key_down_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_key_down |-> (m_kind == KIND_DIT || m_kind == KIND_DAH))
        else $error("key down on a space transaction");

    a_scan_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cnt_reg <= SCAN_END))
        else $error("table scan ran past the end");

endmodule

`default_nettype wire

// ===== dv/tb_morse_element_encoder_unit.sv =====
// Self-checking testbench for morse_element_encoder_unit: directed and random commands.
// Needs mee_pkg and the block's RTL; the expected keyed elements come from a local table model.
module tb_morse_element_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mee_pkg::*;

    localparam int RAND_CMDS      = 185;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT    = 4000;
    localparam int TAIL_CYCLES    = 200;
    localparam logic [SYM_W-1:0] LOWER_A = 8'h61;
    localparam logic [SYM_W-1:0] LOWER_E = 8'h65;

    typedef struct {
        cmd_t             cmd;
        logic [SYM_W-1:0] sym;
        logic [PAT_W-1:0] pat;
        logic [LEN_W-1:0] len;
        int               phase;
        bit               drain_first;
        bit               hold_rx;
    } morse_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [UNIT_W-1:0] units;
        logic              key_down;
        logic [DSYM_W-1:0] decoded_symbol;
        logic              found;
        logic              last;
    } key_element_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [1:0]          s_command = 2'd0;
    logic [SYM_W-1:0]    s_symbol = '0;
    logic [PAT_W-1:0]    s_code_pattern = '0;
    logic [LEN_W-1:0]    s_code_length = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [KIND_W-1:0]   m_kind;
    logic [UNIT_W-1:0]   m_units;
    logic                m_key_down;
    logic [DSYM_W-1:0]   m_decoded_symbol;
    logic                m_found;
    logic                m_last;

    morse_element_encoder_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_symbol         (s_symbol),
        .s_code_pattern   (s_code_pattern),
        .s_code_length    (s_code_length),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_units          (m_units),
        .m_key_down       (m_key_down),
        .m_decoded_symbol (m_decoded_symbol),
        .m_found          (m_found),
        .m_last           (m_last)
    );

    morse_req_t   queued_cmds[$];
    key_element_t pending_elements[$];
    morse_req_t   cur_req;

    // table model used for prediction
    logic [PAT_W-1:0] tbl_pat [TABLE_ENTRIES];
    logic [LEN_W-1:0] tbl_len [TABLE_ENTRIES];
    bit               tbl_valid [TABLE_ENTRIES];
    bit               after_char = 1'b0;

    // generator-side view of loaded letters, for biasing the stimulus
    logic [SYM_W-1:0] gen_loaded[$];
    logic [PAT_W-1:0] gen_pat [TABLE_ENTRIES];
    logic [LEN_W-1:0] gen_len [TABLE_ENTRIES];

    int send_idle_tbl  [4] = '{0, 46, 0, 18};
    int recv_stall_tbl [4] = '{0, 0, 46, 18};
    int rx_stall_pct = 0;
    logic rx_hold_req = 1'b0;
    int rx_hold_left = 0;

    int errors = 0;
    int n_cmds = 0;
    int n_elements = 0;
    int n_answers = 0;
    int quiet_cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic add_req(input cmd_t cmd, input logic [SYM_W-1:0] sym,
                           input logic [PAT_W-1:0] pat, input logic [LEN_W-1:0] len,
                           input int phase = 0, input bit drain = 0, input bit hold = 0);
        morse_req_t req;
        req.cmd = cmd;
        req.sym = sym;
        req.pat = pat;
        req.len = len;
        req.phase = phase;
        req.drain_first = drain;
        req.hold_rx = hold;
        queued_cmds.push_back(req);
        if (cmd == CMD_CLEAR) begin
            gen_loaded.delete();
        end else if (cmd == CMD_LOAD && sym >= LOWER_A && sym < LOWER_A + 8'd26) begin
            gen_loaded.push_back(sym);
            gen_pat[sym] = pat;
            gen_len[sym] = (len > LEN_CAP) ? LEN_CAP : len;
        end
    endtask

    task automatic key_out_elements(input morse_req_t req);
        key_element_t el;
        key_element_t burst[$];
        logic [SYM_W-1:0] c;
        logic [PAT_W-1:0] mask;
        int hit;
        el = '0;
        hit = -1;
        case (req.cmd)
            CMD_CLEAR: begin
                foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
            end
            CMD_LOAD: begin
                if (int'(req.sym) < TABLE_ENTRIES) begin
                    tbl_pat[req.sym] = req.pat;
                    tbl_len[req.sym] = (req.len > LEN_CAP) ? LEN_CAP : req.len;
                    tbl_valid[req.sym] = 1'b1;
                end
            end
            CMD_DECODE: begin
                mask = (req.len >= PAT_W) ? '1 : PAT_W'((1 << req.len) - 1);
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (hit < 0 && tbl_valid[i] && tbl_len[i] == req.len &&
                        ((tbl_pat[i] ^ req.pat) & mask) == '0)
                        hit = i;
                end
                el.kind = KIND_ANSWER;
                el.units = NO_UNITS;
                el.found = (hit >= 0);
                el.decoded_symbol = (hit >= 0) ? DSYM_W'(hit) : '0;
                burst.push_back(el);
            end
            CMD_ENCODE: begin
                if (req.sym == SPACE_SYM) begin
                    after_char = 1'b0;
                    el.kind = KIND_WORD;
                    el.units = WORD_UNITS;
                    burst.push_back(el);
                end else begin
                    c = req.sym;
                    if (c >= UPPER_A && c <= UPPER_Z) c = c + CASE_OFFSET;
                    if (int'(c) < TABLE_ENTRIES && tbl_valid[c]) begin
                        if (after_char) begin
                            el.kind = KIND_GAP;
                            el.units = GAP_UNITS;
                            burst.push_back(el);
                        end
                        el.key_down = 1'b1;
                        for (int i = 0; i < int'(tbl_len[c]); i++) begin
                            el.kind = tbl_pat[c][i] ? KIND_DAH : KIND_DIT;
                            el.units = tbl_pat[c][i] ? DAH_UNITS : DIT_UNITS;
                            burst.push_back(el);
                        end
                        after_char = 1'b1;
                    end
                end
            end
        endcase
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[i]) pending_elements.push_back(burst[i]);
    endtask

    // driver
    always @(posedge aclk) begin
        morse_req_t nxt;
        logic offer;
        logic hold_pulse;
        int stall_next;
        offer = s_valid;
        hold_pulse = 1'b0;
        stall_next = rx_stall_pct;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                key_out_elements(cur_req);
                n_cmds++;
                hold_pulse = cur_req.hold_rx;
                stall_next = recv_stall_tbl[cur_req.phase];
                offer = 1'b0;
            end
            if (!offer && queued_cmds.size() > 0) begin
                nxt = queued_cmds[0];
                if (nxt.drain_first)
                    offer = (pending_elements.size() == 0);
                else
                    offer = ($urandom_range(99) >= send_idle_tbl[nxt.phase]);
                if (offer) begin
                    cur_req = queued_cmds.pop_front();
                    s_command <= cur_req.cmd;
                    s_symbol <= cur_req.sym;
                    s_code_pattern <= cur_req.pat;
                    s_code_length <= cur_req.len;
                end
            end
        end
        s_valid <= offer;
        rx_hold_req <= hold_pulse;
        rx_stall_pct <= stall_next;
    end

    // monitor and checker
    always @(posedge aclk) begin
        key_element_t got;
        key_element_t want;
        logic rdy;
        rdy = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_kind, m_units, m_key_down, m_decoded_symbol, m_found, m_last};
                if (pending_elements.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transaction: kind=%0d units=%0d key=%0b ",
                             $time, got.kind, got.units, got.key_down,
                             "sym=%0d found=%0b last=%0b",
                             got.decoded_symbol, got.found, got.last);
                end else begin
                    want = pending_elements.pop_front();
                    if (got.kind == KIND_ANSWER) n_answers++;
                    else n_elements++;
                    if (got.kind !== want.kind || got.units !== want.units ||
                        got.key_down !== want.key_down ||
                        got.decoded_symbol !== want.decoded_symbol ||
                        got.found !== want.found || got.last !== want.last) begin
                        errors++;
                        $display("%0t: mismatch: expected kind=%0d units=%0d key=%0b ",
                                 $time, want.kind, want.units, want.key_down,
                                 "sym=%0d found=%0b last=%0b",
                                 want.decoded_symbol, want.found, want.last);
                        $display("%0t:           actual kind=%0d units=%0d key=%0b ",
                                 $time, got.kind, got.units, got.key_down,
                                 "sym=%0d found=%0b last=%0b",
                                 got.decoded_symbol, got.found, got.last);
                    end
                end
            end
            if (rx_hold_req) rx_hold_left = RX_HOLD_CYCLES;
            if (rx_hold_left > 0)
                rx_hold_left--;
            else
                rdy = ($urandom_range(99) >= rx_stall_pct);
        end
        m_ready <= rdy;
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("tb_morse_element_encoder_unit: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int ph;
        int prev_ph;
        int pick;
        cmd_t cmd;
        logic [SYM_W-1:0] sym;
        logic [PAT_W-1:0] pat;
        logic [LEN_W-1:0] len;
        logic [PAT_W-1:0] mask;

        // directed
        add_req(CMD_DECODE, 8'h00, 8'h00, 4'd0, 0, 1'b1);
        add_req(CMD_ENCODE, LOWER_A, 8'h00, 4'd0);
        add_req(CMD_ENCODE, SPACE_SYM, 8'h00, 4'd0);
        add_req(CMD_LOAD, LOWER_A, 8'h02, 4'd2);
        add_req(CMD_LOAD, LOWER_E, 8'hFF, 4'd0);
        add_req(CMD_LOAD, 8'h7F, 8'hFF, 4'd15);
        add_req(CMD_LOAD, 8'hC8, 8'h55, 4'd3);
        add_req(CMD_LOAD, 8'h42, 8'h00, 4'd4);
        add_req(CMD_LOAD, 8'h00, 8'h00, 4'd8);
        add_req(CMD_ENCODE, UPPER_A, 8'h00, 4'd0);
        add_req(CMD_ENCODE, LOWER_A, 8'hFF, 4'd15);
        add_req(CMD_ENCODE, 8'hC8, 8'h00, 4'd0);
        add_req(CMD_ENCODE, LOWER_E, 8'h00, 4'd0);
        add_req(CMD_ENCODE, 8'h7F, 8'h00, 4'd0);
        add_req(CMD_ENCODE, 8'h42, 8'h00, 4'd0);
        add_req(CMD_ENCODE, 8'h00, 8'h00, 4'd0);
        add_req(CMD_LOAD, 8'h05, 8'hF2, 4'd2);
        add_req(CMD_DECODE, 8'h00, 8'hFE, 4'd2);
        add_req(CMD_DECODE, 8'h00, 8'h00, 4'd4);
        add_req(CMD_DECODE, 8'h00, 8'hFF, 4'd8);
        add_req(CMD_DECODE, 8'h00, 8'hFF, 4'd15);
        add_req(CMD_ENCODE, SPACE_SYM, 8'h00, 4'd0);
        add_req(CMD_ENCODE, LOWER_E, 8'h00, 4'd0);
        add_req(CMD_CLEAR, 8'hFF, 8'hFF, 4'd15);
        add_req(CMD_DECODE, 8'h00, 8'hFE, 4'd2);

        // random, four idling phases
        prev_ph = -1;
        for (int k = 0; k < RAND_CMDS; k++) begin
            ph = (k * 4) / RAND_CMDS;
            pick = $urandom_range(99);
            sym = SYM_W'($urandom_range(255));
            pat = PAT_W'($urandom_range(255));
            len = LEN_W'($urandom_range(15));
            if (k < 12 || pick < 20) begin
                cmd = CMD_LOAD;
                if ($urandom_range(9) < 7) sym = LOWER_A + SYM_W'($urandom_range(25));
                if ($urandom_range(9) < 8) len = LEN_W'($urandom_range(6, 1));
            end else if (pick < 62) begin
                cmd = CMD_ENCODE;
                if (gen_loaded.size() > 0 && $urandom_range(9) < 7) begin
                    sym = gen_loaded[$urandom_range(gen_loaded.size() - 1)];
                    if ($urandom_range(3) == 0) sym = sym - CASE_OFFSET;
                end
            end else if (pick < 70) begin
                cmd = CMD_ENCODE;
                sym = SPACE_SYM;
            end else if (pick < 97) begin
                cmd = CMD_DECODE;
                if (gen_loaded.size() > 0 && $urandom_range(9) < 6) begin
                    sym = gen_loaded[$urandom_range(gen_loaded.size() - 1)];
                    len = gen_len[sym];
                    mask = (len >= PAT_W) ? '1 : PAT_W'((1 << len) - 1);
                    pat = (pat & ~mask) | (gen_pat[sym] & mask);
                end
            end else begin
                cmd = CMD_CLEAR;
            end
            add_req(cmd, sym, pat, len, ph, ph != prev_ph, k == 20 || k == 110);
            prev_ph = ph;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (queued_cmds.size() > 0 || s_valid || pending_elements.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d commands: %0d keyed elements and %0d decode answers checked,",
                 n_cmds, n_elements, n_answers);
        $display("under free flow, sender gaps, receiver stalls and long output hold-offs");
        if (errors == 0)
            $display("tb_morse_element_encoder_unit: clean");
        else
            $display("tb_morse_element_encoder_unit: errors");
        $finish;
    end

endmodule
